// ===== src/spimbs_pkg.sv =====
package spimbs_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 4;
  localparam int PRESCALE_W = 6;
  localparam int DIV_SEL_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // largest divider select that is honoured; larger codes saturate to it
  localparam logic [DIV_SEL_W-1:0] DIV_SEL_MAX = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 2'd3;

  typedef struct packed {
    logic [DIV_SEL_W-1:0] div_sel;
    logic                 lsb_first;
    logic                 cpol;
    logic                 cpha;
  } cfg_t;

endpackage

// ===== src/spi_master_byte_shifter.sv =====
// SPI master byte shifter, SPI modes 0 to 3.
//
// Usage: every request on the input channel is one system tick of the serial
// engine. It carries start_req with tx_byte and the sampled miso level. For
// every request exactly one result comes out on the output channel: sclk and
// mosi levels, busy_res, a one-tick done_res with rx_byte (held afterwards),
// and write_collision when a start arrives while a transfer is running.
// Configuration (divider select, bit order, polarity, phase) is written
// through cfg_write/cfg_index/cfg_data; the user must write it only while no
// transfer is running, which the block itself does not enforce.
// The result of a request accepted at one edge is registered and presented
// from the next. Throughput is one request per cycle while in_stall is low;
// the state update and the result are a single short pass between the input
// handshake and the result register.
// If the receiver stalls, the result register holds its value and in_stall
// rises in the same cycle, so no request is lost or duplicated; the engine
// itself only advances on accepted requests.
// Reset clears the configuration, the engine (idle, clock level low, held
// byte zero) and empties the result register; result outputs are not reset.
module spi_master_byte_shifter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               start_req,
  input  logic [spimbs_pkg::BYTE_W-1:0]      tx_byte,
  input  logic                               miso,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               sclk,
  output logic                               mosi,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [spimbs_pkg::BYTE_W-1:0]      rx_byte,
  output logic                               write_collision,
  input  logic                               cfg_write,
  input  logic [spimbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spimbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spimbs_pkg::*;

  // configuration
  cfg_t cfg;

  // engine state
  logic [BYTE_W-1:0]     tx_shift, tx_shift_next;
  logic [BYTE_W-1:0]     rx_shift, rx_shift_next;
  logic [COUNT_W-1:0]    bit_count, bit_count_next;
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic                  clock_level, clock_level_next;
  logic                  active, active_next;
  logic [BYTE_W-1:0]     received_hold, received_hold_next;
  logic                  done_next, collision_next;

  logic                  accept;
  logic [DIV_SEL_W-1:0]  sel;
  logic [PRESCALE_W:0]   half;
  logic                  leading;
  logic                  half_end;

  // hold the request while a finished result waits to be taken
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign sel      = (cfg.div_sel > DIV_SEL_MAX) ? DIV_SEL_MAX : cfg.div_sel;
  assign half     = (PRESCALE_W+1)'(1) << sel;
  assign half_end = ({1'b0, prescale_count} + (PRESCALE_W+1)'(1)) >= half;
  assign leading  = (clock_level == cfg.cpol);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIVIDER:  cfg.div_sel   <= cfg_data;
        CFG_LSB:      cfg.lsb_first <= cfg_data[0];
        CFG_POLARITY: cfg.cpol      <= cfg_data[0];
        CFG_PHASE:    cfg.cpha      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tx_shift_next       = tx_shift;
    rx_shift_next       = rx_shift;
    bit_count_next      = bit_count;
    prescale_count_next = prescale_count;
    clock_level_next    = clock_level;
    active_next         = active;
    received_hold_next  = received_hold;
    done_next           = 1'b0;
    collision_next      = 1'b0;

    if (active) begin
      collision_next = start_req;
      if (half_end) begin
        prescale_count_next = '0;
        clock_level_next    = ~clock_level;
        if (leading) begin
          if (!cfg.cpha) begin
            rx_shift_next = cfg.lsb_first ? {miso, rx_shift[BYTE_W-1:1]}
                                          : {rx_shift[BYTE_W-2:0], miso};
          end else if (bit_count != '0) begin
            tx_shift_next = cfg.lsb_first ? {1'b0, tx_shift[BYTE_W-1:1]}
                                          : {tx_shift[BYTE_W-2:0], 1'b0};
          end
        end else begin
          if (!cfg.cpha) begin
            tx_shift_next = cfg.lsb_first ? {1'b0, tx_shift[BYTE_W-1:1]}
                                          : {tx_shift[BYTE_W-2:0], 1'b0};
          end else begin
            rx_shift_next = cfg.lsb_first ? {miso, rx_shift[BYTE_W-1:1]}
                                          : {rx_shift[BYTE_W-2:0], miso};
          end
          bit_count_next = bit_count + COUNT_W'(1);
          // eighth trailing edge: hand over the byte and drop back to idle
          if (bit_count_next[COUNT_W-1]) begin
            received_hold_next = rx_shift_next;
            active_next        = 1'b0;
            bit_count_next     = '0;
            done_next          = 1'b1;
            clock_level_next   = cfg.cpol;
          end
        end
      end else begin
        prescale_count_next = prescale_count + PRESCALE_W'(1);
      end
    end else begin
      clock_level_next = cfg.cpol;
      if (start_req) begin
        tx_shift_next       = tx_byte;
        rx_shift_next       = '0;
        bit_count_next      = '0;
        prescale_count_next = '0;
        active_next         = 1'b1;
      end
    end
  end

  // advance the engine only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift       <= '0;
      rx_shift       <= '0;
      bit_count      <= '0;
      prescale_count <= '0;
      clock_level    <= 1'b0;
      active         <= 1'b0;
      received_hold  <= '0;
    end else if (accept) begin
      tx_shift       <= tx_shift_next;
      rx_shift       <= rx_shift_next;
      bit_count      <= bit_count_next;
      prescale_count <= prescale_count_next;
      clock_level    <= clock_level_next;
      active         <= active_next;
      received_hold  <= received_hold_next;
    end
  end

  // result register: load on accept, empty once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sclk            <= clock_level_next;
      mosi            <= active_next &&
                         (cfg.lsb_first ? tx_shift_next[0] : tx_shift_next[BYTE_W-1]);
      busy_res        <= active_next;
      done_res        <= done_next;
      rx_byte         <= received_hold_next;
      write_collision <= collision_next;
    end
  end

  // a start seen while a transfer runs must be flagged in its result
  a_collision: assert property (@(posedge clk) disable iff (rst)
    accept && start_req && active |=> out_valid && write_collision)
    else $error("collision not flagged");

  // the done pulse always ends the transfer
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !active)
    else $error("done while still busy");

  // an idle engine holds no partial bit count
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !active |-> bit_count == '0)
    else $error("bit count left over while idle");

  // a stalled result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rx_byte) && $stable(sclk))
    else $error("stalled result changed");

endmodule
